### rtl/sbfd_pkg.sv
package sbfd_pkg;

  // Bin store geometry.
  localparam int NUM_BINS = 1024;
  localparam int ADDR_W   = $clog2(NUM_BINS);
  localparam int CLR_W    = ADDR_W + 1;

  // Field widths.
  localparam int BIN_W      = 10;
  localparam int MAG_W      = 24;
  localparam int SUM_W      = 32;
  localparam int GAIN_W     = 17;
  localparam int LEAK_W     = 16;
  localparam int CNT_W      = 16;
  localparam int DUCK_W     = 8;
  localparam int HB_W       = 11;
  localparam int PROD_W     = SUM_W + LEAK_W;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Output queue.
  localparam int OUT_FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);
  localparam int FIFO_CNT_W     = FIFO_PTR_W + 1;
  localparam int FILL_W         = FIFO_CNT_W + 1;

  localparam logic [GAIN_W-1:0] UNITY    = GAIN_W'(65536);
  localparam logic [DUCK_W-1:0] DUCK_MAX = '1;

  typedef enum logic [2:0] {
    DIR_IDLE = 3'b001,
    DIR_UP   = 3'b010,
    DIR_DOWN = 3'b100
  } ramp_dir_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_THRESHOLD    = 3'd0,
    CFG_LEAK_FACTOR  = 3'd1,
    CFG_RAMP_STEP    = 3'd2,
    CFG_HOLD_FRAMES  = 3'd3,
    CFG_WAIT_GO      = 3'd4,
    CFG_TRIP_LIMIT   = 3'd5,
    CFG_BLOCK_FRAMES = 3'd6,
    CFG_HIGHEST_BIN  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_index;
    logic [MAG_W-1:0] magnitude;
  } in_item_t;

  typedef struct packed {
    logic [BIN_W-1:0]  out_bin;
    logic [GAIN_W-1:0] gain;
  } out_item_t;

  typedef struct packed {
    logic [SUM_W-1:0]  threshold;
    logic [LEAK_W-1:0] leak_factor;
    logic [GAIN_W-1:0] ramp_step;
    logic [CNT_W-1:0]  hold_frames;
    logic [CNT_W-1:0]  wait_go_frames;
    logic [DUCK_W-1:0] trip_limit;
    logic [CNT_W-1:0]  block_frames;
    logic [HB_W-1:0]   highest_bin;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [GAIN_W-1:0] gain;
    ramp_dir_t         dir;
    logic [CNT_W-1:0]  hold_left;
    logic [CNT_W-1:0]  wait_left;
    logic [DUCK_W-1:0] duck_count;
    logic [CNT_W-1:0]  block_left;
  } bin_state_t;

  localparam cfg_t CFG_RESET = '{
    threshold:      32'hFFFF_FFFF,
    leak_factor:    16'd58982,
    ramp_step:      17'd6554,
    hold_frames:    16'd10,
    wait_go_frames: 16'd0,
    trip_limit:     8'd4,
    block_frames:   16'd100,
    highest_bin:    11'd1024
  };

  localparam bin_state_t STATE_RESET = '{
    sum:        '0,
    gain:       UNITY,
    dir:        DIR_IDLE,
    hold_left:  '0,
    wait_left:  '0,
    duck_count: '0,
    block_left: '0
  };

endpackage

### rtl/sbfd_state_mem.sv
module sbfd_state_mem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [sbfd_pkg::ADDR_W-1:0] rd_addr,
  output sbfd_pkg::bin_state_t       rd_data,
  input  logic                       wr_en,
  input  logic [sbfd_pkg::ADDR_W-1:0] wr_addr,
  input  sbfd_pkg::bin_state_t       wr_data,
  output logic                       clear_busy
);

  sbfd_pkg::bin_state_t mem [sbfd_pkg::NUM_BINS];
  logic [sbfd_pkg::CLR_W-1:0] clr_cnt;

  // After reset every entry is swept back to its initial state, one per cycle.
  assign clear_busy = (clr_cnt != sbfd_pkg::CLR_W'(sbfd_pkg::NUM_BINS));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clear_busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (clear_busy) begin
      mem[clr_cnt[sbfd_pkg::ADDR_W-1:0]] <= sbfd_pkg::STATE_RESET;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

### rtl/sbfd_update.sv
module sbfd_update (
  input  sbfd_pkg::cfg_t                cfg,
  input  logic                          run,
  input  logic [sbfd_pkg::PROD_W-1:0]   prod,
  input  logic [sbfd_pkg::MAG_W-1:0]    magnitude,
  input  sbfd_pkg::bin_state_t          cur,
  output sbfd_pkg::bin_state_t          nxt
);

  logic [sbfd_pkg::SUM_W:0]    sum_wide;
  logic [sbfd_pkg::SUM_W-1:0]  sum_new;
  logic [sbfd_pkg::GAIN_W-1:0] step;
  logic [sbfd_pkg::GAIN_W:0]   rise;

  // Leaked sum plus the new magnitude, clipped to the sum width.
  assign sum_wide = {1'b0, prod[sbfd_pkg::PROD_W-1:sbfd_pkg::LEAK_W]}
                  + (sbfd_pkg::SUM_W + 1)'(magnitude);
  assign sum_new  = sum_wide[sbfd_pkg::SUM_W] ? '1 : sum_wide[sbfd_pkg::SUM_W-1:0];

  assign step = (cfg.ramp_step == '0) ? sbfd_pkg::GAIN_W'(1) : cfg.ramp_step;
  assign rise = {1'b0, cur.gain} + {1'b0, step};

  always_comb begin
    nxt     = cur;
    nxt.sum = sum_new;
    if (run) begin
      if (cur.block_left != '0) begin
        nxt.block_left = cur.block_left - 1'b1;
      end else if (cur.hold_left != '0) begin
        nxt.hold_left = cur.hold_left - 1'b1;
      end else begin
        case (cur.dir)
          sbfd_pkg::DIR_IDLE: begin
            if (cur.gain == '0) begin
              nxt.dir = sbfd_pkg::DIR_UP;
            end else if (sum_new > cfg.threshold) begin
              if (cur.wait_left == '0) begin
                nxt.dir = sbfd_pkg::DIR_DOWN;
                if (cur.duck_count != sbfd_pkg::DUCK_MAX) begin
                  nxt.duck_count = cur.duck_count + 1'b1;
                end
              end else begin
                nxt.wait_left = cur.wait_left - 1'b1;
              end
            end
          end
          sbfd_pkg::DIR_DOWN: begin
            if (step > cur.gain) begin
              nxt.gain      = '0;
              nxt.dir       = sbfd_pkg::DIR_IDLE;
              nxt.hold_left = cfg.hold_frames;
              if (cur.duck_count >= cfg.trip_limit) begin
                nxt.block_left = cfg.block_frames;
                nxt.duck_count = '0;
              end
            end else begin
              nxt.gain = cur.gain - step;
            end
          end
          sbfd_pkg::DIR_UP: begin
            if (rise > {1'b0, sbfd_pkg::UNITY}) begin
              nxt.gain      = sbfd_pkg::UNITY;
              nxt.dir       = sbfd_pkg::DIR_IDLE;
              nxt.wait_left = cfg.wait_go_frames;
            end else begin
              nxt.gain = rise[sbfd_pkg::GAIN_W-1:0];
            end
          end
          default: begin
            nxt.dir = cur.dir;
          end
        endcase
      end
    end
  end

endmodule

### rtl/sbfd_out_fifo.sv
module sbfd_out_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  sbfd_pkg::out_item_t            push_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sbfd_pkg::out_item_t            out_data,
  output logic [sbfd_pkg::FIFO_CNT_W-1:0] count
);

  sbfd_pkg::out_item_t entries [sbfd_pkg::OUT_FIFO_DEPTH];
  logic [sbfd_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [sbfd_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic                            pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/spectral_bin_feedback_ducker.sv
// Per-bin feedback ducker. Each input beat carries one frame of one spectral
// bin (bin index and magnitude); each output beat returns that bin's gain in
// Q1.16, with 65536 as unity. Both channels use valid/ready; results leave in
// the order the bins arrived, exactly one output beat per input beat.
// Settings are written through a plain write port (enable, index, data) and
// may only change while no beats are in flight.
// An accepted beat is registered into stage 1 as its state is read, then
// into stage 2 for the update, then into the output queue, which offers it.
// Throughput, set by the per-bin read-modify-write of the state memory, is
// one beat per cycle while in_ready is high; repeated hits on the same bin are
// forwarded, so they do not slow the stream. Reset restores default settings
// and starts a clearing pass that writes the initial state into all 1024 bins,
// one per cycle, with in_ready low until it ends. A four-entry output queue
// absorbs receiver stalls: otherwise in_ready drops only when the queue plus
// pipeline beats fill it, and resumes as soon as the receiver takes beats.
module spectral_bin_feedback_ducker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sbfd_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sbfd_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [sbfd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sbfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  sbfd_pkg::cfg_t cfg;

  // Settings registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= sbfd_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (sbfd_pkg::cfg_reg_t'(cfg_addr))
        sbfd_pkg::CFG_THRESHOLD:    cfg.threshold      <= cfg_data[sbfd_pkg::SUM_W-1:0];
        sbfd_pkg::CFG_LEAK_FACTOR:  cfg.leak_factor    <= cfg_data[sbfd_pkg::LEAK_W-1:0];
        sbfd_pkg::CFG_RAMP_STEP:    cfg.ramp_step      <= cfg_data[sbfd_pkg::GAIN_W-1:0];
        sbfd_pkg::CFG_HOLD_FRAMES:  cfg.hold_frames    <= cfg_data[sbfd_pkg::CNT_W-1:0];
        sbfd_pkg::CFG_WAIT_GO:      cfg.wait_go_frames <= cfg_data[sbfd_pkg::CNT_W-1:0];
        sbfd_pkg::CFG_TRIP_LIMIT:   cfg.trip_limit     <= cfg_data[sbfd_pkg::DUCK_W-1:0];
        sbfd_pkg::CFG_BLOCK_FRAMES: cfg.block_frames   <= cfg_data[sbfd_pkg::CNT_W-1:0];
        sbfd_pkg::CFG_HIGHEST_BIN:  cfg.highest_bin    <= cfg_data[sbfd_pkg::HB_W-1:0];
        default:                    cfg                <= cfg;
      endcase
    end
  end

  logic                             in_fire;
  logic                             clear_busy;
  logic [sbfd_pkg::FIFO_CNT_W-1:0]  fifo_count;
  logic [sbfd_pkg::FILL_W-1:0]      fill;

  // Stage 1: item waits for its state word from memory.
  logic                             s1_valid;
  sbfd_pkg::in_item_t               s1_item;
  sbfd_pkg::bin_state_t             rd_state;
  sbfd_pkg::bin_state_t             s1_state;
  logic [sbfd_pkg::PROD_W-1:0]      s1_prod;

  // Stage 2: leaked sum product is ready; envelope advances.
  logic                             s2_valid;
  sbfd_pkg::in_item_t               s2_item;
  sbfd_pkg::bin_state_t             s2_state;
  logic [sbfd_pkg::PROD_W-1:0]      s2_prod;
  sbfd_pkg::bin_state_t             s2_new;
  logic                             s2_in_range;
  logic                             s2_run;
  sbfd_pkg::out_item_t              s2_result;

  // Copy of the word written at the last edge, which the read at that same
  // edge did not see yet.
  logic                             wb_valid;
  logic [sbfd_pkg::BIN_W-1:0]       wb_bin;
  sbfd_pkg::bin_state_t             wb_state;

  // Every beat in the pipeline already owns a queue slot, so the queue never
  // overflows and the pipeline never has to stall.
  assign fill     = sbfd_pkg::FILL_W'(fifo_count) + sbfd_pkg::FILL_W'(s1_valid)
                  + sbfd_pkg::FILL_W'(s2_valid);
  assign in_ready = !clear_busy && (fill < sbfd_pkg::FILL_W'(sbfd_pkg::OUT_FIFO_DEPTH));
  assign in_fire  = in_valid && in_ready;

  sbfd_state_mem u_mem (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (in_fire),
    .rd_addr    (sbfd_pkg::ADDR_W'(in_data.bin_index)),
    .rd_data    (rd_state),
    .wr_en      (s2_valid && s2_in_range),
    .wr_addr    (sbfd_pkg::ADDR_W'(s2_item.bin_index)),
    .wr_data    (s2_new),
    .clear_busy (clear_busy)
  );

  // Pick the freshest copy of this bin's state: the beat one stage ahead
  // first, then the word written at the edge of the read, then memory.
  always_comb begin
    if (s2_valid && (s2_item.bin_index == s1_item.bin_index)) begin
      s1_state = s2_new;
    end else if (wb_valid && (wb_bin == s1_item.bin_index)) begin
      s1_state = wb_state;
    end else begin
      s1_state = rd_state;
    end
  end

  assign s1_prod = sbfd_pkg::PROD_W'(s1_state.sum) * sbfd_pkg::PROD_W'(cfg.leak_factor);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      wb_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
      s2_valid <= s1_valid;
      wb_valid <= s2_valid && s2_in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= in_data;
    end
    s2_item  <= s1_item;
    s2_state <= s1_state;
    s2_prod  <= s1_prod;
    wb_bin   <= s2_item.bin_index;
    wb_state <= s2_new;
  end

  assign s2_in_range = (32'(s2_item.bin_index) < sbfd_pkg::NUM_BINS);
  assign s2_run      = s2_in_range
                     && ({1'b0, s2_item.bin_index} < cfg.highest_bin);

  sbfd_update u_update (
    .cfg       (cfg),
    .run       (s2_run),
    .prod      (s2_prod),
    .magnitude (s2_item.magnitude),
    .cur       (s2_state),
    .nxt       (s2_new)
  );

  // Bins outside the store report unity gain and leave no trace.
  assign s2_result.out_bin = s2_item.bin_index;
  assign s2_result.gain    = s2_in_range ? s2_new.gain : sbfd_pkg::UNITY;

  sbfd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (s2_result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (fifo_count)
  );

endmodule
